### src/tgpr_pkg.sv
// shared types, constants and codes for the text glyph pixel renderer
package tgpr_pkg;

   // default sizing of the glyph store and cursor steps
   localparam int GLYPH_COUNT_DEF  = 128;
   localparam int LINE_ADVANCE_DEF = 10;
   localparam int CHAR_ADVANCE_DEF = 8;

   // command codes
   localparam logic [1:0] CMD_LOAD    = 2'd0;
   localparam logic [1:0] CMD_DRAW    = 2'd1;
   localparam logic [1:0] CMD_NEWLINE = 2'd2;
   localparam logic [1:0] CMD_HOME    = 2'd3;

   // control register indexes
   localparam int          CSR_IDX_W     = 3;
   localparam logic [2:0]  CSR_FRAME_BASE = 3'd0;
   localparam logic [2:0]  CSR_ROW_PITCH  = 3'd1;
   localparam logic [2:0]  CSR_INK_RED    = 3'd2;
   localparam logic [2:0]  CSR_INK_GREEN  = 3'd3;
   localparam logic [2:0]  CSR_INK_BLUE   = 3'd4;

   // register reset values
   localparam logic [31:0] FRAME_BASE_RST = 32'd0;
   localparam logic [15:0] ROW_PITCH_RST  = 16'd3072;
   localparam logic [7:0]  INK_RST        = 8'd255;

   // request beat
   typedef struct packed {
      logic [1:0] cmd;
      logic [6:0] char_code;
      logic [2:0] glyph_row;
      logic [7:0] row_bits;
   } req_type;

   // response beat: one pixel write
   typedef struct packed {
      logic [31:0] pixel_address;
      logic [7:0]  pixel_red;
      logic [7:0]  pixel_green;
      logic [7:0]  pixel_blue;
      logic        last_pixel;
   } rsp_type;

endpackage

### src/tgpr_glyph_store.sv
// glyph bitmap memory: one write port, one registered read port
module tgpr_glyph_store #(
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [7:0]               wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [7:0]               rd_data
);

   logic [7:0] mem [DEPTH];
   logic [7:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port, data registered
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### src/text_glyph_pixel_renderer_top.sv
// top level of the text glyph pixel renderer: cursor, sequencer, address unit
//
//  port group | direction | handshake          | beat
//  req_       | in        | req_valid/req_stall | req_type: command and glyph data
//  rsp_       | out       | rsp_valid/rsp_stall | rsp_type: one pixel write
//  csr_       | in        | csr_valid/csr_ready | register index and write data
//
// load, newline and home complete without leaving the idle state.
// a draw fetches the eight glyph rows and forms the start address, then scans one
// glyph bit per cycle up to the last set bit, holding while a set bit's pixel is stalled.
// one shared 32-bit adder steps the pixel address; the row fetch uses the memory port.
// reset is synchronous; the glyph store is not cleared and the cursor returns home.
// a stalled response holds the bit scan at a set bit; req_stall stays high for the whole draw.
module text_glyph_pixel_renderer_top
   import tgpr_pkg::*;
#(
   parameter int GLYPH_COUNT  = GLYPH_COUNT_DEF,
   parameter int LINE_ADVANCE = LINE_ADVANCE_DEF,
   parameter int CHAR_ADVANCE = CHAR_ADVANCE_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  req_type              req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rsp_type              rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]          csr_data
);

   localparam int STORE_DEPTH = GLYPH_COUNT * 8;
   localparam int AW          = $clog2(STORE_DEPTH);

   // sequencer states
   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_FETCH = 2'd1;
   localparam logic [1:0] ST_SCAN  = 2'd2;

   logic [1:0]  state_ff, state_in;
   logic [31:0] frame_base_ff;
   logic [15:0] row_pitch_ff;
   logic [7:0]  ink_red_ff, ink_green_ff, ink_blue_ff;
   logic [15:0] cursor_row_ff, cursor_row_in;
   logic [15:0] cursor_col_ff, cursor_col_in;
   logic [AW-1:0] glyph_base_ff, glyph_base_in;
   logic [3:0]  step_ff, step_in;
   logic [2:0]  col_ff, col_in;
   logic [63:0] bits_ff, bits_in;
   logic [31:0] prod_ff;
   logic [17:0] col3_ff;
   logic [31:0] addr_ff, addr_in;
   logic [31:0] row_addr_ff, row_addr_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_data_ff, rsp_data_in;

   logic        req_accept;
   logic        slot_free;
   logic        scan_step;
   logic        scan_done;
   logic        emit;
   logic [31:0] add_a, add_b, add_sum;
   logic        st_wr_en;
   logic [AW-1:0] st_wr_addr;
   logic        st_rd_en;
   logic [AW-1:0] st_rd_addr;
   logic [7:0]  st_rd_data;

   assign req_accept = req_valid && !req_stall;
   assign req_stall  = (state_ff != ST_IDLE);
   assign csr_ready  = 1'b1;
   assign slot_free  = !rsp_valid_ff || !rsp_stall;
   assign scan_step  = (state_ff == ST_SCAN) && (!bits_ff[0] || slot_free);
   assign scan_done  = scan_step && (bits_ff[63:1] == 63'd0);
   assign emit       = scan_step && bits_ff[0];

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_base_ff <= FRAME_BASE_RST;
         row_pitch_ff  <= ROW_PITCH_RST;
         ink_red_ff    <= INK_RST;
         ink_green_ff  <= INK_RST;
         ink_blue_ff   <= INK_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_FRAME_BASE: frame_base_ff <= csr_data;
            CSR_ROW_PITCH:  row_pitch_ff  <= csr_data[15:0];
            CSR_INK_RED:    ink_red_ff    <= csr_data[7:0];
            CSR_INK_GREEN:  ink_green_ff  <= csr_data[7:0];
            CSR_INK_BLUE:   ink_blue_ff   <= csr_data[7:0];
            default: ;
         endcase
      end
   end

   // glyph store access: loads write, the fetch phase reads row by row
   assign st_wr_en   = req_accept && (req_data.cmd == CMD_LOAD);
   assign st_wr_addr = AW'((int'(req_data.char_code) % GLYPH_COUNT) * 8
                           + int'(req_data.glyph_row));
   assign st_rd_en   = (state_ff == ST_FETCH) && !step_ff[3];
   assign st_rd_addr = glyph_base_ff + AW'(step_ff[2:0]);

   tgpr_glyph_store #(
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (st_wr_en),
      .wr_addr (st_wr_addr),
      .wr_data (req_data.row_bits),
      .rd_en   (st_rd_en),
      .rd_addr (st_rd_addr),
      .rd_data (st_rd_data)
   );

   // start-address products, formed while rows are fetched
   always_ff @(posedge clock) begin
      prod_ff <= 32'(cursor_row_ff) * 32'(row_pitch_ff);
      col3_ff <= 18'(cursor_col_ff) * 18'd3;
   end

   // shared address adder
   always_comb begin
      add_a = addr_ff;
      add_b = 32'd3;
      if (state_ff == ST_FETCH) begin
         if (step_ff == 4'd1) begin
            add_a = frame_base_ff;
            add_b = prod_ff;
         end else begin
            add_a = addr_ff;
            add_b = 32'(col3_ff);
         end
      end else if (col_ff == 3'd7) begin
         add_a = row_addr_ff;
         add_b = 32'(row_pitch_ff);
      end
   end
   assign add_sum = add_a + add_b;

   // sequencer and datapath next values
   always_comb begin
      state_in      = state_ff;
      cursor_row_in = cursor_row_ff;
      cursor_col_in = cursor_col_ff;
      glyph_base_in = glyph_base_ff;
      step_in       = step_ff;
      col_in        = col_ff;
      bits_in       = bits_ff;
      addr_in       = addr_ff;
      row_addr_in   = row_addr_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_data_in   = rsp_data_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               case (req_data.cmd)
                  CMD_DRAW: begin
                     glyph_base_in = AW'((int'(req_data.char_code) % GLYPH_COUNT) * 8);
                     step_in       = 4'd0;
                     state_in      = ST_FETCH;
                  end
                  CMD_NEWLINE: begin
                     cursor_row_in = cursor_row_ff + 16'(LINE_ADVANCE);
                     cursor_col_in = 16'd0;
                  end
                  CMD_HOME: begin
                     cursor_row_in = 16'd0;
                     cursor_col_in = 16'd0;
                  end
                  default: ;
               endcase
            end
         end
         ST_FETCH: begin
            // row data arrives in the cycle after its read
            if (step_ff != 4'd0) begin
               bits_in = {st_rd_data, bits_ff[63:8]};
            end
            if (step_ff == 4'd1 || step_ff == 4'd2) begin
               addr_in = add_sum;
            end
            if (step_ff == 4'd2) begin
               row_addr_in = add_sum;
            end
            step_in = step_ff + 4'd1;
            if (step_ff == 4'd8) begin
               col_in   = 3'd0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (emit) begin
               rsp_valid_in              = 1'b1;
               rsp_data_in.pixel_address = addr_ff;
               rsp_data_in.pixel_red     = ink_red_ff;
               rsp_data_in.pixel_green   = ink_green_ff;
               rsp_data_in.pixel_blue    = ink_blue_ff;
               rsp_data_in.last_pixel    = (bits_ff[63:1] == 63'd0);
            end
            if (scan_step) begin
               bits_in = {1'b0, bits_ff[63:1]};
               col_in  = col_ff + 3'd1;
               addr_in = add_sum;
               if (col_ff == 3'd7) begin
                  row_addr_in = add_sum;
               end
            end
            if (scan_done) begin
               cursor_col_in = cursor_col_ff + 16'(CHAR_ADVANCE);
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         cursor_row_ff <= 16'd0;
         cursor_col_ff <= 16'd0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cursor_row_ff <= cursor_row_in;
         cursor_col_ff <= cursor_col_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload and working registers
   always_ff @(posedge clock) begin
      glyph_base_ff <= glyph_base_in;
      step_ff       <= step_in;
      col_ff        <= col_in;
      bits_ff       <= bits_in;
      addr_ff       <= addr_in;
      row_addr_ff   <= row_addr_in;
      rsp_data_ff   <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // a draw always enters the fetch phase
   a_draw_fetch: assert property (@(posedge clock) disable iff (reset)
      req_accept && (req_data.cmd == CMD_DRAW) |=> state_ff == ST_FETCH)
      else $error("draw did not start fetch");

   // the fetch phase ends in the scan after its last step
   a_fetch_len: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_FETCH && step_ff == 4'd8 |=> state_ff == ST_SCAN)
      else $error("fetch phase length wrong");

   // the last pixel of a character closes the scan
   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      emit && (bits_ff[63:1] == 63'd0) |=> state_ff == ST_IDLE && rsp_data_ff.last_pixel)
      else $error("scan ran past last pixel");

   // the cursor column moves only on an accepted command or at the end of a scan
   a_col_move: assert property (@(posedge clock) disable iff (reset)
      !$stable(cursor_col_ff) |-> $past(req_accept || scan_done))
      else $error("cursor column moved unexpectedly");

endmodule
